FILE: design/gmds_pkg.sv
// ----------------------------------------------------------------------------
// Grid maze search package
// Shared types, sizes and move tables for the grid maze depth-first search.
// ----------------------------------------------------------------------------
package gmds_pkg;

  // Grid and stack sizes.
  localparam int GridDim    = 16;
  localparam int CoordW     = $clog2(GridDim);
  localparam int CellW      = 2 * CoordW;
  localparam int CellCount  = GridDim * GridDim;
  localparam int StackDepth = 256;
  localparam int StackAw    = $clog2(StackDepth);
  localparam int SpW        = StackAw + 1;
  localparam int DirW       = 3;
  localparam int StepW      = 10;
  localparam int ClrW       = CellW + 1;

  localparam logic [SpW-1:0]   StackFull = SpW'(StackDepth);
  localparam logic [StepW-1:0] StepMax   = '1;
  localparam logic [DirW-1:0]  DirDone   = DirW'(4);
  localparam logic [ClrW-1:0]  ClrLast   = ClrW'(CellCount - 1);
  localparam logic [ClrW-1:0]  ClrEnd    = ClrW'(CellCount);

  // Request codes.
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqSolve = 1'b1;

  // Result codes.
  localparam logic OutEscaped = 1'b0;
  localparam logic OutFailed  = 1'b1;

  // Row and column offsets for right, down, up, left, one bit wider than a
  // coordinate so that a step off either edge sets the top bit.
  localparam logic [CoordW:0] MoveRow [4] = '{
    (CoordW+1)'(0), (CoordW+1)'(1), '1, (CoordW+1)'(0)
  };
  localparam logic [CoordW:0] MoveCol [4] = '{
    (CoordW+1)'(1), (CoordW+1)'(0), (CoordW+1)'(0), '1
  };

  // Input transfer payload.
  typedef struct packed {
    logic              req_type;
    logic [CoordW-1:0] cell_row;
    logic [CoordW-1:0] cell_col;
    logic              is_wall;
    logic [CoordW-1:0] start_row;
    logic [CoordW-1:0] start_col;
    logic [CoordW-1:0] exit_row;
    logic [CoordW-1:0] exit_col;
  } in_item_t;

  // Output transfer payload.
  typedef struct packed {
    logic             outcome;
    logic [StepW-1:0] step_count;
  } out_item_t;

  // One entry of the cell memory.
  typedef struct packed {
    logic wall;
    logic visited;
  } cell_entry_t;

  // One entry of the backtrack stack.
  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [DirW-1:0]   dir;
  } stack_entry_t;

  // Access request to the cell memory.
  typedef struct packed {
    logic             rd_en;
    logic [CellW-1:0] rd_addr;
    logic             wr_en;
    logic [CellW-1:0] wr_addr;
    cell_entry_t      wr_data;
  } cell_req_t;

  // Access request to the stack memory.
  typedef struct packed {
    logic               rd_en;
    logic [StackAw-1:0] rd_addr;
    logic               wr_en;
    logic [StackAw-1:0] wr_addr;
    stack_entry_t       wr_data;
  } stack_req_t;

endpackage

FILE: design/gmds_cell_mem.sv
// ----------------------------------------------------------------------------
// Grid maze cell memory
// One wall bit and one visited bit per grid cell, one write and one read
// port, read data registered.
// ----------------------------------------------------------------------------
module gmds_cell_mem (
  input  logic                   clk_i,
  input  gmds_pkg::cell_req_t    req_i,
  output gmds_pkg::cell_entry_t  rd_data_o
);

  gmds_pkg::cell_entry_t mem_q [gmds_pkg::CellCount];
  gmds_pkg::cell_entry_t rd_data_q;

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/gmds_stack_mem.sv
// ----------------------------------------------------------------------------
// Grid maze backtrack stack memory
// Holds the cell and next direction of each level of the search path, one
// write and one read port, read data registered.
// ----------------------------------------------------------------------------
module gmds_stack_mem (
  input  logic                    clk_i,
  input  gmds_pkg::stack_req_t    req_i,
  output gmds_pkg::stack_entry_t  rd_data_o
);

  gmds_pkg::stack_entry_t mem_q [gmds_pkg::StackDepth];
  gmds_pkg::stack_entry_t rd_data_q;

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/grid_maze_dfs_search_unit.sv
// ----------------------------------------------------------------------------
// Grid maze depth-first search unit
// Stores a 16 x 16 wall map and searches it depth first from a start cell
// toward an exit cell with a backtrack stack held in memory.
// ----------------------------------------------------------------------------
// After reset the unit clears the cell memory and takes no transfer during
// that time. A load transfer writes one wall bit. A solve transfer first
// sweeps the cell memory to clear the visited bits, then walks the maze:
// each probe of a neighbor inside the grid reads the cell memory and then
// decides, a probe off the grid or onto the exit needs no read, and an
// exhausted cell is followed by a pop of the stack. The result is then
// handed to the output register. One result transfer follows each solve.
// A new transfer is taken while the previous result still waits at the
// output.
// ----------------------------------------------------------------------------
module grid_maze_dfs_search_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gmds_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gmds_pkg::out_item_t out_data_o
);

  typedef enum logic [6:0] {
    StWipe  = 7'b0000001,
    StIdle  = 7'b0000010,
    StClear = 7'b0000100,
    StProbe = 7'b0001000,
    StPop   = 7'b0010000,
    StCheck = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  state_e                          state_q, state_d;
  logic [gmds_pkg::ClrW-1:0]       clr_q, clr_d;
  logic [gmds_pkg::CoordW-1:0]     cur_row_q, cur_row_d;
  logic [gmds_pkg::CoordW-1:0]     cur_col_q, cur_col_d;
  logic [gmds_pkg::DirW-1:0]       dir_q, dir_d;
  logic [gmds_pkg::SpW-1:0]        sp_q, sp_d;
  logic [gmds_pkg::StepW-1:0]      steps_q, steps_d;
  logic [gmds_pkg::CoordW-1:0]     start_row_q, start_row_d;
  logic [gmds_pkg::CoordW-1:0]     start_col_q, start_col_d;
  logic [gmds_pkg::CoordW-1:0]     exit_row_q, exit_row_d;
  logic [gmds_pkg::CoordW-1:0]     exit_col_q, exit_col_d;
  logic [gmds_pkg::CoordW-1:0]     nb_row_q, nb_row_d;
  logic [gmds_pkg::CoordW-1:0]     nb_col_q, nb_col_d;
  logic                            outcome_q, outcome_d;
  logic                            out_valid_q, out_valid_d;
  gmds_pkg::out_item_t             out_data_q, out_data_d;

  gmds_pkg::cell_req_t             cell_req;
  gmds_pkg::cell_entry_t           cell_rd;
  gmds_pkg::stack_req_t            stack_req;
  gmds_pkg::stack_entry_t          stack_rd;

  logic                            in_xfer;
  logic [gmds_pkg::CoordW:0]       nb_row_ext;
  logic [gmds_pkg::CoordW:0]       nb_col_ext;
  logic [gmds_pkg::StepW-1:0]      steps_inc;
  logic [gmds_pkg::CellW-1:0]      clr_wr_addr;

  gmds_cell_mem u_cell_mem (
    .clk_i     (clk_i),
    .req_i     (cell_req),
    .rd_data_o (cell_rd)
  );

  gmds_stack_mem u_stack_mem (
    .clk_i     (clk_i),
    .req_i     (stack_req),
    .rd_data_o (stack_rd)
  );

  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Neighbor in the current direction; the top bit flags a step off the grid.
  assign nb_row_ext = {1'b0, cur_row_q} + gmds_pkg::MoveRow[dir_q[1:0]];
  assign nb_col_ext = {1'b0, cur_col_q} + gmds_pkg::MoveCol[dir_q[1:0]];

  // Saturating step counter increment.
  assign steps_inc = (steps_q == gmds_pkg::StepMax) ? steps_q
                                                    : steps_q + gmds_pkg::StepW'(1);

  // The visited sweep writes back the entry it read in the cycle before.
  assign clr_wr_addr = clr_q[gmds_pkg::CellW-1:0] - gmds_pkg::CellW'(1);

  // Search sequencer.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    dir_d       = dir_q;
    sp_d        = sp_q;
    steps_d     = steps_q;
    start_row_d = start_row_q;
    start_col_d = start_col_q;
    exit_row_d  = exit_row_q;
    exit_col_d  = exit_col_q;
    nb_row_d    = nb_row_q;
    nb_col_d    = nb_col_q;
    outcome_d   = outcome_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    cell_req    = '0;
    stack_req   = '0;

    // The waiting result leaves on an output transfer.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StWipe: begin
        // Clear every cell after reset: no walls, nothing visited.
        cell_req.wr_en   = 1'b1;
        cell_req.wr_addr = clr_q[gmds_pkg::CellW-1:0];
        cell_req.wr_data = '0;
        if (clr_q == gmds_pkg::ClrLast) begin
          clr_d   = '0;
          state_d = StIdle;
        end else begin
          clr_d = clr_q + gmds_pkg::ClrW'(1);
        end
      end

      StIdle: begin
        if (in_xfer) begin
          if (in_data_i.req_type == gmds_pkg::ReqLoad) begin
            cell_req.wr_en           = 1'b1;
            cell_req.wr_addr         = {in_data_i.cell_row, in_data_i.cell_col};
            cell_req.wr_data.wall    = in_data_i.is_wall;
            cell_req.wr_data.visited = 1'b0;
          end else begin
            start_row_d = in_data_i.start_row;
            start_col_d = in_data_i.start_col;
            exit_row_d  = in_data_i.exit_row;
            exit_col_d  = in_data_i.exit_col;
            steps_d     = '0;
            clr_d       = '0;
            state_d     = StClear;
          end
        end
      end

      StClear: begin
        // Pipelined sweep: read one cell, write back the one before it with
        // its wall kept and only the start cell marked visited.
        if (clr_q != gmds_pkg::ClrEnd) begin
          cell_req.rd_en   = 1'b1;
          cell_req.rd_addr = clr_q[gmds_pkg::CellW-1:0];
        end
        if (clr_q != '0) begin
          cell_req.wr_en           = 1'b1;
          cell_req.wr_addr         = clr_wr_addr;
          cell_req.wr_data.wall    = cell_rd.wall;
          cell_req.wr_data.visited = (clr_wr_addr == {start_row_q, start_col_q});
        end
        if (clr_q == gmds_pkg::ClrEnd) begin
          clr_d = '0;
          if (start_row_q == exit_row_q && start_col_q == exit_col_q) begin
            outcome_d = gmds_pkg::OutEscaped;
            state_d   = StDone;
          end else begin
            cur_row_d = start_row_q;
            cur_col_d = start_col_q;
            dir_d     = '0;
            sp_d      = '0;
            state_d   = StProbe;
          end
        end else begin
          clr_d = clr_q + gmds_pkg::ClrW'(1);
        end
      end

      StProbe: begin
        if (dir_q == gmds_pkg::DirDone) begin
          // All directions tried: count the dead end and backtrack.
          steps_d = steps_inc;
          if (sp_q == '0) begin
            outcome_d = gmds_pkg::OutFailed;
            state_d   = StDone;
          end else begin
            sp_d              = sp_q - gmds_pkg::SpW'(1);
            stack_req.rd_en   = 1'b1;
            stack_req.rd_addr = sp_d[gmds_pkg::StackAw-1:0];
            state_d           = StPop;
          end
        end else if (nb_row_ext == {1'b0, exit_row_q} &&
                     nb_col_ext == {1'b0, exit_col_q}) begin
          // The exit is taken before any wall test.
          steps_d   = steps_inc;
          outcome_d = gmds_pkg::OutEscaped;
          state_d   = StDone;
        end else if (nb_row_ext[gmds_pkg::CoordW] || nb_col_ext[gmds_pkg::CoordW]) begin
          // Off the grid counts as a wall.
          dir_d = dir_q + gmds_pkg::DirW'(1);
        end else begin
          nb_row_d         = nb_row_ext[gmds_pkg::CoordW-1:0];
          nb_col_d         = nb_col_ext[gmds_pkg::CoordW-1:0];
          cell_req.rd_en   = 1'b1;
          cell_req.rd_addr = {nb_row_ext[gmds_pkg::CoordW-1:0],
                              nb_col_ext[gmds_pkg::CoordW-1:0]};
          state_d          = StCheck;
        end
      end

      StPop: begin
        cur_row_d = stack_rd.row;
        cur_col_d = stack_rd.col;
        dir_d     = stack_rd.dir;
        state_d   = StProbe;
      end

      StCheck: begin
        if (!cell_rd.wall && !cell_rd.visited) begin
          // Step onto the neighbor and remember where to resume here.
          cell_req.wr_en           = 1'b1;
          cell_req.wr_addr         = {nb_row_q, nb_col_q};
          cell_req.wr_data.wall    = 1'b0;
          cell_req.wr_data.visited = 1'b1;
          if (sp_q != gmds_pkg::StackFull) begin
            stack_req.wr_en       = 1'b1;
            stack_req.wr_addr     = sp_q[gmds_pkg::StackAw-1:0];
            stack_req.wr_data.row = cur_row_q;
            stack_req.wr_data.col = cur_col_q;
            stack_req.wr_data.dir = dir_q + gmds_pkg::DirW'(1);
            sp_d                  = sp_q + gmds_pkg::SpW'(1);
          end
          steps_d   = steps_inc;
          cur_row_d = nb_row_q;
          cur_col_d = nb_col_q;
          dir_d     = '0;
        end else begin
          dir_d = dir_q + gmds_pkg::DirW'(1);
        end
        state_d = StProbe;
      end

      StDone: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_data_d.outcome    = outcome_q;
          out_data_d.step_count = steps_q;
          state_d               = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StWipe;
      clr_q       <= '0;
      sp_q        <= '0;
      steps_q     <= '0;
      dir_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sp_q        <= sp_d;
      steps_q     <= steps_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_row_q   <= cur_row_d;
    cur_col_q   <= cur_col_d;
    start_row_q <= start_row_d;
    start_col_q <= start_col_d;
    exit_row_q  <= exit_row_d;
    exit_col_q  <= exit_col_d;
    nb_row_q    <= nb_row_d;
    nb_col_q    <= nb_col_d;
    outcome_q   <= outcome_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
